### sv/assert_macros.svh
// Assertion macros shared by the circle rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mcr_pkg.sv
// Types and constants shared by the midpoint circle rasterizer modules.
package mcr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_W    = 7;
    localparam int OUT_W       = 12;
    localparam int OFS_W       = 7;
    localparam int TERM_W      = 9;
    localparam int ERR_W       = 12;
    localparam int DIAM_W      = 8;
    localparam int STEP_LIMIT  = 64;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RADIUS_W-1:0]   circle_radius;
    } t_circle_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_plus_dx;
        logic signed [OUT_W-1:0] x_minus_dx;
        logic signed [OUT_W-1:0] x_plus_dy;
        logic signed [OUT_W-1:0] x_minus_dy;
        logic signed [OUT_W-1:0] y_plus_dy;
        logic signed [OUT_W-1:0] y_minus_dy;
        logic signed [OUT_W-1:0] y_plus_dx;
        logic signed [OUT_W-1:0] y_minus_dx;
        logic                    last_step;
    } t_circle_out;

    // A circle waiting in the queue; the radius is already clamped and nonzero.
    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RADIUS_W-1:0]   radius;
    } t_job;

endpackage

### sv/mcr_front.sv
// Front end: takes circle commands, drops empty circles and clamps the radius.
module mcr_front #(
    parameter int MAX_RADIUS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mcr_pkg::t_circle_in i_item,
    input  logic                i_queue_full,
    output logic                o_push,
    output mcr_pkg::t_job       o_job
);
    import mcr_pkg::*;

    localparam logic [RADIUS_W-1:0] MaxR = RADIUS_W'(MAX_RADIUS);

    logic accept;

    assign busy   = i_queue_full;
    assign accept = start && !i_queue_full;

    // A zero radius draws nothing, so such a command never reaches the queue.
    assign o_push = accept && (i_item.circle_radius != '0);

    always_comb begin
        o_job.center_x = i_item.center_x;
        o_job.center_y = i_item.center_y;
        o_job.radius   = (i_item.circle_radius > MaxR) ? MaxR : i_item.circle_radius;
    end

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_push_radius, o_push, o_job.radius != '0 && o_job.radius <= MaxR, "bad radius")
    `ASSERT_IMPL(a_push_needs_room, o_push, !i_queue_full, "push into a full queue")
    `ASSERT_IMPL(a_busy_blocks_push, busy, !o_push, "push while busy")

endmodule

### sv/mcr_queue.sv
// Short circle queue between the front end and the walk engine.
module mcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcr_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output mcr_pkg::t_job o_data,
    output logic          o_empty
);
    import mcr_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, r_count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_IMPL(a_no_pop_empty, i_pop, !o_empty, "pop from an empty queue")
    `ASSERT_NEXT(a_push_fills, i_push && !i_pop, !o_empty, "queue empty after a push")

endmodule

### sv/mcr_walk.sv
// Walk engine: runs the midpoint circle walk and emits one octant point set per cycle.
module mcr_walk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  mcr_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output mcr_pkg::t_circle_out o_result
);
    import mcr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_strobe, n_strobe;
    t_circle_out             r_result, n_result;
    logic [COORD_BITS-1:0]   r_cx, r_cy;
    logic [OFS_W-1:0]        r_x, n_x;
    logic [OFS_W-1:0]        r_y, n_y;
    logic [TERM_W-1:0]       r_sx, n_sx;
    logic [TERM_W-1:0]       r_sy, n_sy;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [DIAM_W-1:0]       r_diam;
    logic [CNT_W-1:0]        r_cnt;

    logic signed [ERR_W-1:0] err_y;
    logic [OUT_W-1:0]        cx_w, cy_w, x_w, y_w;
    logic                    last;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // One walk step: the y move first, then the x move on the updated error.
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_sx  = r_sx;
        n_sy  = r_sy;
        err_y = r_err;
        if (r_err[ERR_W-1] || (r_err == '0)) begin
            n_y   = r_y + 1'b1;
            err_y = r_err + $signed({{(ERR_W-TERM_W){1'b0}}, r_sy});
            n_sy  = r_sy + TERM_W'(2);
        end
        n_err = err_y;
        if (!err_y[ERR_W-1] && (err_y != '0)) begin
            if (r_x != '0) begin
                n_x = r_x - 1'b1;
            end
            n_sx  = r_sx + TERM_W'(2);
            n_err = err_y + $signed({{(ERR_W-TERM_W){1'b0}}, n_sx})
                          - $signed({{(ERR_W-DIAM_W){1'b0}}, r_diam});
        end
        last = (n_x < n_y) || (r_cnt == CNT_W'(STEP_LIMIT-1));
    end

    always_comb begin
        cx_w = OUT_W'(r_cx);
        cy_w = OUT_W'(r_cy);
        x_w  = OUT_W'(r_x);
        y_w  = OUT_W'(r_y);
        n_result.x_plus_dx  = cx_w + x_w;
        n_result.x_minus_dx = cx_w - x_w;
        n_result.x_plus_dy  = cx_w + y_w;
        n_result.x_minus_dy = cx_w - y_w;
        n_result.y_plus_dy  = cy_w + y_w;
        n_result.y_minus_dy = cy_w - y_w;
        n_result.y_plus_dx  = cy_w + x_w;
        n_result.y_minus_dx = cy_w - x_w;
        n_result.last_step  = last;
    end

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_strobe = 1'b1;
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        if (o_pop) begin
            r_cx   <= i_job.center_x;
            r_cy   <= i_job.center_y;
            r_x    <= OFS_W'(i_job.radius - 1'b1);
            r_y    <= '0;
            r_sx   <= TERM_W'(1);
            r_sy   <= TERM_W'(1);
            r_diam <= DIAM_W'({i_job.radius, 1'b0});
            r_err  <= ERR_W'(1) - $signed({{(ERR_W-RADIUS_W-1){1'b0}}, i_job.radius, 1'b0});
            r_cnt  <= '0;
        end else if (r_state == S_WALK) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_err <= n_err;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_WALK) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_strobe_from_walk, r_strobe, $past(r_state) == S_WALK, "stray result")
    `ASSERT_IMPL(a_last_ends, r_strobe && r_result.last_step, r_state == S_IDLE, "walk overrun")
    `ASSERT_IMPL(a_pop_only_idle, o_pop, r_state == S_IDLE, "circle loaded during a walk")

endmodule

### sv/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer.
// A circle command (center and radius) is taken when start is high and busy is low; busy
// rises only while the two-entry circle queue is full, so two circles can wait behind
// the one being drawn. A radius of zero is accepted and produces nothing; a radius above
// MAX_RADIUS is clamped to it. The walk engine loads a circle while idle and then produces
// one result per cycle until the walk of that circle ends. Each result is shown for
// exactly one cycle with o_strobe high and must be captured then: there is no way to
// hold results off. The last result of each circle has last_step set.
module midpoint_circle_rasterizer #(
    parameter int MAX_RADIUS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mcr_pkg::t_circle_in  i_item,
    output logic                 o_strobe,
    output mcr_pkg::t_circle_out o_result
);
    import mcr_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    mcr_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    mcr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_job),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_data (head_job),
        .o_empty(queue_empty)
    );

    mcr_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule
